>>> hw/rtl/sce_pkg.sv
// Shared types and constants for the sine/cosine encoder angle pipeline.
package sce_pkg;

    // Default configuration of the top level
    localparam int DEF_ADC_BITS        = 12;
    localparam int DEF_ANGLE_FRAC_BITS = 13;

    // Ratio format and quotient width (ratio can reach exactly 1.0)
    localparam int RATIO_FRAC = 16;
    localparam int QUOT_W     = RATIO_FRAC + 1;

    // Polynomial coefficients and angle constants, Q16
    localparam logic signed [17:0] COEF_C7     = -18'sd3047;
    localparam logic signed [17:0] COEF_C5     = 18'sd10441;
    localparam logic signed [17:0] COEF_C3     = -18'sd21471;
    localparam logic signed [20:0] HALF_PI_Q16 = 21'sd102944;
    localparam logic signed [20:0] PI_Q16      = 21'sd205887;

    // Configuration port and field widths
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 16;
    localparam int OFFSET_W   = 16;
    localparam int ABS_W      = 16;
    localparam int REL_W      = 17;

    // Register reset values
    localparam logic [15:0] SINE_MID_RST   = 16'd1931;
    localparam logic [15:0] COSINE_MID_RST = 16'd2059;
    localparam logic [15:0] ALIGN_OFF_RST  = 16'hD666;  // -10650

    // Register indexes
    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_SINE_MID   = 2'd0,
        CFG_COSINE_MID = 2'd1,
        CFG_ALIGN_OFF  = 2'd2
    } t_cfg_idx;

    // Octant and quadrant flags that travel beside the ratio
    typedef struct packed {
        logic s_neg;
        logic c_neg;
        logic swap;
        logic zero;
    } t_side;

endpackage

>>> hw/rtl/sce_div.sv
// Pipelined restoring divider: one quotient bit per stage, ratio = min * 2^16 / max.
module sce_div #(
    parameter int ADC_BITS = sce_pkg::DEF_ADC_BITS
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [ADC_BITS:0]           i_mn,
    input  logic [ADC_BITS:0]           i_mx,
    input  sce_pkg::t_side              i_side,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [sce_pkg::QUOT_W-1:0]  o_quot,
    output sce_pkg::t_side              o_side
);
    import sce_pkg::*;

    localparam int NQ = QUOT_W;
    localparam int DW = ADC_BITS + 1;

    logic              r_v    [NQ];
    logic [DW-1:0]     r_rem  [NQ];
    logic [DW-1:0]     r_mx   [NQ];
    logic [QUOT_W-1:0] r_q    [NQ];
    t_side             r_side [NQ];
    logic [NQ:0]       stage_rdy;

    assign stage_rdy[NQ] = i_ready;

    for (genvar j = 0; j < NQ; j++) begin : g_stage
        logic              v_in;
        logic [DW:0]       trial;
        logic [DW-1:0]     mx_in;
        logic [QUOT_W-1:0] q_in;
        t_side             side_in;
        logic              qbit;
        logic [DW:0]       diff;
        logic [DW-1:0]     n_rem;
        logic [QUOT_W-1:0] n_q;

        // First stage takes the remainder unshifted, later ones shift by one
        if (j == 0) begin : g_first
            assign v_in    = i_valid;
            assign trial   = {1'b0, i_mn};
            assign mx_in   = i_mx;
            assign q_in    = '0;
            assign side_in = i_side;
        end else begin : g_next
            assign v_in    = r_v[j-1];
            assign trial   = {r_rem[j-1], 1'b0};
            assign mx_in   = r_mx[j-1];
            assign q_in    = r_q[j-1];
            assign side_in = r_side[j-1];
        end

        // Trial subtract
        always_comb begin
            diff  = trial - {1'b0, mx_in};
            qbit  = (trial >= {1'b0, mx_in});
            n_rem = qbit ? diff[DW-1:0] : trial[DW-1:0];
            n_q   = q_in | (QUOT_W'(qbit) << (NQ - 1 - j));
        end

        assign stage_rdy[j] = !r_v[j] || stage_rdy[j+1];

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[j] <= 1'b0;
            end else if (stage_rdy[j]) begin
                r_v[j] <= v_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (v_in && stage_rdy[j]) begin
                r_rem[j]  <= n_rem;
                r_mx[j]   <= mx_in;
                r_q[j]    <= n_q;
                r_side[j] <= side_in;
            end
        end
    end

    assign o_ready = stage_rdy[0];
    assign o_valid = r_v[NQ-1];
    assign o_quot  = r_q[NQ-1];
    assign o_side  = r_side[NQ-1];

endmodule

>>> hw/rtl/sincos_encoder_angle.sv
// Sine/cosine encoder angle: top level with centering, folding, division, polynomial and output.
//
// Each beat on the slave stream carries one sine/cosine ADC pair; each beat on the
// master stream carries the absolute angle atan2(s, c) and that angle minus the
// alignment offset, both radians scaled by 2^ANGLE_FRAC_BITS. A new pair is taken
// every cycle unless back-pressure from the master stream holds the pipeline, and
// its result passes through 25 register stages (2 front stages, 17 divider stages
// at one quotient bit each, 5 multiply stages, 1 output stage) to the master stream.
// Stages advance independently, so bubbles close up while the output is stalled.
// Configuration writes take effect at once and are meant for when the pipeline is
// empty.
module sincos_encoder_angle #(
    parameter int  ADC_BITS        = sce_pkg::DEF_ADC_BITS,
    parameter int  ANGLE_FRAC_BITS = sce_pkg::DEF_ANGLE_FRAC_BITS,
    localparam int IN_DW           = ((2 * ADC_BITS + 7) / 8) * 8,
    localparam int OUT_DW          = ((sce_pkg::ABS_W + sce_pkg::REL_W + 7) / 8) * 8
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // sine_sample, cosine_sample (lowest bits first)
    input  logic [IN_DW-1:0]                s_axis_tdata,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // absolute_angle, relative_angle (lowest bits first)
    output logic [OUT_DW-1:0]               m_axis_tdata,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    input  logic                            i_cfg_we,
    input  logic [sce_pkg::CFG_ADDR_W-1:0]  i_cfg_addr,
    input  logic [sce_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import sce_pkg::*;

    localparam int A  = ADC_BITS;
    localparam int SH = RATIO_FRAC - ANGLE_FRAC_BITS;
    localparam logic [20:0] HALF_R = (SH == 0) ? 21'd0 : 21'(1 << (SH - 1));
    localparam logic signed [20:0] MAG_MAX = 21'sd205887 + $signed(HALF_R) >>> SH;

    typedef struct packed {
        logic [QUOT_W-1:0] a;
        t_side             side;
    } t_carry;

    // Q16 rounding, half up: floor((x + 2^15) / 2^16)
    function automatic logic signed [19:0] rnd_q16(input logic signed [35:0] x);
        logic signed [35:0] t;
        begin
            t = x + 36'sd32768;
            return t[35:16];
        end
    endfunction

    // Configuration registers
    logic [A-1:0]               r_mid_s, r_mid_c;
    logic signed [OFFSET_W-1:0] r_off;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mid_s <= SINE_MID_RST[A-1:0];
            r_mid_c <= COSINE_MID_RST[A-1:0];
            r_off   <= ALIGN_OFF_RST;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_addr))
                CFG_SINE_MID:   r_mid_s <= i_cfg_data[A-1:0];
                CFG_COSINE_MID: r_mid_c <= i_cfg_data[A-1:0];
                CFG_ALIGN_OFF:  r_off   <= i_cfg_data[OFFSET_W-1:0];
                default: ;
            endcase
        end
    end

    // Stage valids and ready chain
    logic r_f1_v, r_f2_v, r_p1_v, r_p2_v, r_p3_v, r_p4_v, r_p5_v, r_out_v;
    logic out_rdy, p5_rdy, p4_rdy, p3_rdy, p2_rdy, p1_rdy, f2_rdy, f1_rdy;
    logic div_in_rdy, div_v;
    logic [QUOT_W-1:0] div_q;
    t_side             div_side;

    assign out_rdy = m_axis_tready || !r_out_v;
    assign p5_rdy  = !r_p5_v || out_rdy;
    assign p4_rdy  = !r_p4_v || p5_rdy;
    assign p3_rdy  = !r_p3_v || p4_rdy;
    assign p2_rdy  = !r_p2_v || p3_rdy;
    assign p1_rdy  = !r_p1_v || p2_rdy;
    assign f2_rdy  = !r_f2_v || div_in_rdy;
    assign f1_rdy  = !r_f1_v || f2_rdy;
    assign s_axis_tready = f1_rdy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f1_v  <= 1'b0;
            r_f2_v  <= 1'b0;
            r_p1_v  <= 1'b0;
            r_p2_v  <= 1'b0;
            r_p3_v  <= 1'b0;
            r_p4_v  <= 1'b0;
            r_p5_v  <= 1'b0;
            r_out_v <= 1'b0;
        end else begin
            if (f1_rdy)  r_f1_v  <= s_axis_tvalid;
            if (f2_rdy)  r_f2_v  <= r_f1_v;
            if (p1_rdy)  r_p1_v  <= div_v;
            if (p2_rdy)  r_p2_v  <= r_p1_v;
            if (p3_rdy)  r_p3_v  <= r_p2_v;
            if (p4_rdy)  r_p4_v  <= r_p3_v;
            if (p5_rdy)  r_p5_v  <= r_p4_v;
            if (out_rdy) r_out_v <= r_p5_v;
        end
    end

    // F1: subtract midpoints
    logic signed [A:0] r_s, r_c, n_s, n_c;

    assign n_s = $signed({1'b0, s_axis_tdata[A-1:0]}) - $signed({1'b0, r_mid_s});
    assign n_c = $signed({1'b0, s_axis_tdata[2*A-1:A]}) - $signed({1'b0, r_mid_c});

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && f1_rdy) begin
            r_s <= n_s;
            r_c <= n_c;
        end
    end

    // F2: magnitudes, octant fold
    logic [A:0] as_w, ac_w, r_mn, r_mx;
    t_side      n_side, r_f2_side;

    always_comb begin
        as_w        = r_s[A] ? (~r_s + 1'b1) : r_s;
        ac_w        = r_c[A] ? (~r_c + 1'b1) : r_c;
        n_side.s_neg = r_s[A];
        n_side.c_neg = r_c[A];
        n_side.swap  = (as_w > ac_w);
        n_side.zero  = (as_w == '0) && (ac_w == '0);
    end

    always_ff @(posedge i_clk) begin
        if (r_f1_v && f2_rdy) begin
            r_mn      <= n_side.swap ? ac_w : as_w;
            r_mx      <= n_side.swap ? as_w : ac_w;
            r_f2_side <= n_side;
        end
    end

    sce_div #(
        .ADC_BITS (ADC_BITS)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_f2_v),
        .o_ready (div_in_rdy),
        .i_mn    (r_mn),
        .i_mx    (r_mx),
        .i_side  (r_f2_side),
        .o_valid (div_v),
        .i_ready (p1_rdy),
        .o_quot  (div_q),
        .o_side  (div_side)
    );

    // P1: square of the ratio
    t_carry      r_p1_k, r_p2_k, r_p3_k, r_p4_k, r_p5_k;
    logic [33:0] r_sq;

    always_ff @(posedge i_clk) begin
        if (div_v && p1_rdy) begin
            r_p1_k.a    <= div_q;
            r_p1_k.side <= div_side;
            r_sq        <= div_q * div_q;
        end
    end

    // P2: round square, times c7
    logic [34:0]        sq_rnd;
    logic [16:0]        sv_w, r_sv2, r_sv3;
    logic signed [35:0] r_t2, r_t3, r_t4, r_t5;

    assign sq_rnd = {1'b0, r_sq} + 35'd32768;
    assign sv_w   = sq_rnd[32:16];

    always_ff @(posedge i_clk) begin
        if (r_p1_v && p2_rdy) begin
            r_p2_k <= r_p1_k;
            r_sv2  <= sv_w;
            r_t2   <= COEF_C7 * $signed({1'b0, sv_w});
        end
    end

    // P3..P5: Horner steps of the polynomial
    logic signed [19:0] p1_w, p2_w, p3_w;

    assign p1_w = rnd_q16(r_t2) + 20'(COEF_C5);
    assign p2_w = rnd_q16(r_t3) + 20'(COEF_C3);
    assign p3_w = rnd_q16(r_t4);

    always_ff @(posedge i_clk) begin
        if (r_p2_v && p3_rdy) begin
            r_p3_k <= r_p2_k;
            r_sv3  <= r_sv2;
            r_t3   <= $signed(p1_w[17:0]) * $signed({1'b0, r_sv2});
        end
        if (r_p3_v && p4_rdy) begin
            r_p4_k <= r_p3_k;
            r_t4   <= $signed(p2_w[17:0]) * $signed({1'b0, r_sv3});
        end
        if (r_p4_v && p5_rdy) begin
            r_p5_k <= r_p4_k;
            r_t5   <= $signed(p3_w[17:0]) * $signed({1'b0, r_p4_k.a});
        end
    end

    // OUT: octant and quadrant correction, rounding, sign, offset
    logic signed [20:0] r_w, ang_w;
    logic [20:0]        mag_w;
    logic signed [20:0] r_ang;
    logic [REL_W-1:0]   r_rel;
    logic signed [20:0] rel_w;

    always_comb begin
        r_w = $signed({4'b0, r_p5_k.a}) + 21'(rnd_q16(r_t5));
        if (r_p5_k.side.swap) begin
            r_w = HALF_PI_Q16 - r_w;
        end
        if (r_p5_k.side.c_neg) begin
            r_w = PI_Q16 - r_w;
        end
        if (r_w < 0) begin
            r_w = '0;
        end
        mag_w = (r_w + HALF_R) >> SH;
        ang_w = r_p5_k.side.s_neg ? -$signed(mag_w) : $signed(mag_w);
        if (r_p5_k.side.zero) begin
            ang_w = '0;
        end
        rel_w = ang_w - 21'(r_off);
    end

    always_ff @(posedge i_clk) begin
        if (r_p5_v && out_rdy) begin
            r_ang <= ang_w;
            r_rel <= rel_w[REL_W-1:0];
        end
    end

    assign m_axis_tvalid = r_out_v;
    assign m_axis_tdata  = OUT_DW'({r_rel, r_ang[ABS_W-1:0]});

    // Checks; a zero pair leaves the divider output meaningless, so the ratio checks exempt it
    a_ang_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_v |-> (r_ang <= MAG_MAX) && (r_ang >= -MAG_MAX))
        else $error("angle beyond pi");

    a_ratio_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_p1_v |-> r_p1_k.side.zero || (r_p1_k.a <= 17'h10000))
        else $error("ratio above one");

    a_square_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_p2_v |-> r_p2_k.side.zero || (r_sv2 <= 17'h10000))
        else $error("ratio square above one");

    a_front_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> r_f1_v && r_f2_v)
        else $error("input stalled with front stages free");

endmodule
